// File: sv/jse_pkg.sv
// Shared types, constants and helpers for the JSON string escaper.
package jse_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      logic       empty_string;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       run_end;
   } rsp_payload_type;

   localparam logic [1:0] BODY_NONE  = 2'd0;
   localparam logic [1:0] BODY_CHAR  = 2'd1;
   localparam logic [1:0] BODY_ESC   = 2'd2;
   localparam logic [1:0] BODY_UNI   = 2'd3;

   localparam int unsigned IDX_W = 4;

   localparam logic [6:0] CHAR_QUOTE  = 7'h22;
   localparam logic [6:0] CHAR_BSLASH = 7'h5c;
   localparam logic [6:0] CHAR_U      = 7'h75;
   localparam logic [6:0] CHAR_N      = 7'h6e;
   localparam logic [6:0] CHAR_B      = 7'h62;
   localparam logic [6:0] CHAR_F      = 7'h66;
   localparam logic [6:0] CHAR_R      = 7'h72;
   localparam logic [6:0] CHAR_T      = 7'h74;

   localparam logic [15:0] HIGH_SURR_BASE = 16'hd7c0;
   localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;

   typedef struct packed {
      logic        open_q;
      logic        close_q;
      logic [1:0]  kind;
      logic [6:0]  ch;
      logic        pair;
      logic [15:0] hi;
      logic [15:0] lo;
   } cmd_type;

   function automatic logic [6:0] hex_char(input logic [3:0] n);
      logic [6:0] r;
      if (n < 4'd10) begin
         r = 7'h30 + {3'b000, n};
      end else begin
         r = 7'h57 + {3'b000, n};
      end
      return r;
   endfunction

endpackage

// File: sv/jse_front.sv
// Front end: takes input transfers, tracks UTF-8 state and builds output commands.
module jse_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  jse_pkg::req_payload_type req_payload,
   input  logic                     q_full,
   output logic                     q_push,
   output jse_pkg::cmd_type         q_cmd
);
   import jse_pkg::*;

   logic [1:0]  bp_ff, bp_in, bp_cur;
   logic [20:0] acc_ff, acc_in, acc_cur, cp;
   logic        uni;
   logic        accept;
   logic [7:0]  b;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_payload.data_byte;

   always_comb begin
      q_cmd   = '0;
      uni     = 1'b0;
      cp      = '0;
      bp_cur  = bp_ff;
      acc_cur = acc_ff;
      bp_in   = bp_ff;
      acc_in  = acc_ff;
      if (req_payload.empty_string) begin
         q_cmd.open_q  = 1'b1;
         q_cmd.close_q = 1'b1;
         bp_in         = '0;
         acc_in        = '0;
      end else begin
         if (req_payload.first_byte) begin
            bp_cur  = '0;
            acc_cur = '0;
         end
         q_cmd.open_q = req_payload.first_byte;
         bp_in        = bp_cur;
         acc_in       = acc_cur;
         if (bp_cur != 2'd0) begin
            acc_in = {acc_cur[14:0], b[5:0]};
            bp_in  = bp_cur - 2'd1;
            if (bp_in == 2'd0) begin
               uni    = 1'b1;
               cp     = acc_in;
               acc_in = '0;
            end
         end else begin
            case (b) inside
               8'h22, 8'h5c: begin
                  q_cmd.kind = BODY_ESC;
                  q_cmd.ch   = b[6:0];
               end
               8'h0a: begin
                  q_cmd.kind = BODY_ESC;
                  q_cmd.ch   = CHAR_N;
               end
               8'h08: begin
                  q_cmd.kind = BODY_ESC;
                  q_cmd.ch   = CHAR_B;
               end
               8'h0c: begin
                  q_cmd.kind = BODY_ESC;
                  q_cmd.ch   = CHAR_F;
               end
               8'h0d: begin
                  q_cmd.kind = BODY_ESC;
                  q_cmd.ch   = CHAR_R;
               end
               8'h09: begin
                  q_cmd.kind = BODY_ESC;
                  q_cmd.ch   = CHAR_T;
               end
               [8'h20:8'h7e]: begin
                  q_cmd.kind = BODY_CHAR;
                  q_cmd.ch   = b[6:0];
               end
               [8'h00:8'h7f]: begin
                  uni = 1'b1;
                  cp  = {13'd0, b};
               end
               [8'h80:8'hbf]: begin
                  uni = 1'b1;
                  cp  = {15'd0, b[5:0]};
               end
               [8'hc0:8'hdf]: begin
                  bp_in  = 2'd1;
                  acc_in = {16'd0, b[4:0]};
               end
               [8'he0:8'hef]: begin
                  bp_in  = 2'd2;
                  acc_in = {17'd0, b[3:0]};
               end
               default: begin
                  bp_in  = 2'd3;
                  acc_in = {18'd0, b[2:0]};
               end
            endcase
         end
         if (req_payload.last_byte) begin
            if (bp_in != 2'd0) begin
               uni = 1'b1;
               cp  = acc_in;
            end
            bp_in         = '0;
            acc_in        = '0;
            q_cmd.close_q = 1'b1;
         end
      end
      if (uni) begin
         q_cmd.kind = BODY_UNI;
         q_cmd.pair = (cp[20:16] != 5'd0);
         q_cmd.hi   = q_cmd.pair ? HIGH_SURR_BASE + {5'd0, cp[20:10]} : cp[15:0];
         q_cmd.lo   = {LOW_SURR_TAG, cp[9:0]};
      end
   end

   assign q_push = accept && (q_cmd.open_q || q_cmd.close_q || (q_cmd.kind != BODY_NONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         bp_ff  <= '0;
         acc_ff <= '0;
      end else if (accept) begin
         bp_ff  <= bp_in;
         acc_ff <= acc_in;
      end
   end

   a_empty_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.empty_string |=> bp_ff == 2'd0 && acc_ff == '0)
      else $error("empty string left sequence state behind");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.last_byte |=> bp_ff == 2'd0 && acc_ff == '0)
      else $error("last byte left sequence state behind");

endmodule

// File: sv/jse_fifo.sv
// Command queue between the front end and the serializer.
module jse_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jse_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output jse_pkg::cmd_type head_cmd
);
   import jse_pkg::*;

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count past depth");

endmodule

// File: sv/jse_back.sv
// Back end: serializes one queued command into characters behind an output register.
module jse_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  jse_pkg::cmd_type         head_cmd,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output jse_pkg::rsp_payload_type rsp_payload
);
   import jse_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] nbody, total, j, jj;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic [6:0]       ch;
   logic [15:0]      word;
   logic             second_half;
   logic             is_last;
   logic             load;

   always_comb begin
      case (head_cmd.kind)
         BODY_NONE: nbody = IDX_W'(0);
         BODY_CHAR: nbody = IDX_W'(1);
         BODY_ESC:  nbody = IDX_W'(2);
         default:   nbody = head_cmd.pair ? IDX_W'(12) : IDX_W'(6);
      endcase
      total       = IDX_W'(head_cmd.open_q) + nbody + IDX_W'(head_cmd.close_q);
      is_last     = (idx_ff == total - IDX_W'(1));
      j           = idx_ff - IDX_W'(head_cmd.open_q);
      second_half = (j >= IDX_W'(6));
      jj          = second_half ? j - IDX_W'(6) : j;
      word        = second_half ? head_cmd.lo : head_cmd.hi;
      ch          = CHAR_QUOTE;
      if (head_cmd.open_q && idx_ff == '0) begin
         ch = CHAR_QUOTE;
      end else if (j < nbody) begin
         case (head_cmd.kind)
            BODY_CHAR: ch = head_cmd.ch;
            BODY_ESC:  ch = (j == '0) ? CHAR_BSLASH : head_cmd.ch;
            default: begin
               case (jj)
                  IDX_W'(0): ch = CHAR_BSLASH;
                  IDX_W'(1): ch = CHAR_U;
                  IDX_W'(2): ch = hex_char(word[15:12]);
                  IDX_W'(3): ch = hex_char(word[11:8]);
                  IDX_W'(4): ch = hex_char(word[7:4]);
                  default:   ch = hex_char(word[3:0]);
               endcase
            end
         endcase
      end
   end

   assign load  = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = load && is_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.out_char  = ch;
         rsp_in.run_end   = is_last;
         idx_in           = is_last ? '0 : idx_ff + IDX_W'(1);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff < total)
      else $error("character index past command length");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == '0)
      else $error("character index nonzero with no command");

   a_pop_ends_run: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff && rsp_ff.run_end)
      else $error("command retired without run end");

endmodule

// File: sv/json_string_escaper_core.sv
// First character of an item goes through the command queue, then the output
// register, and can wait behind earlier items or an output stall. Throughput: one
// character per cycle unless stalled; items with no characters are not queued.
// A QUEUE_DEPTH-entry command queue decouples input from the serializer.
// Reset clears the UTF-8 sequence state, the queue and the output valid flag.
module json_string_escaper_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  jse_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output jse_pkg::rsp_payload_type rsp_payload
);
   import jse_pkg::*;

   logic    q_push, q_pop, q_full, head_valid;
   cmd_type push_cmd, head_cmd;

   jse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   jse_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   jse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
